// ===== hdl/tbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Table interpolator package
// Widths, table geometry, microcode encodings and the microcode ROM shared
// by the sequencer, the datapath, the breakpoint table and the top level.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int DATA_W      = 32;
    localparam int CLAMP_W     = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;

    // Stream payload layout.
    localparam int IN_IDX_W     = 6;
    localparam int IN_TDATA_W   = 104;
    localparam int IN_KEY_LSB   = IN_IDX_W;
    localparam int IN_VAL_LSB   = IN_KEY_LSB + DATA_W;
    localparam int IN_QUERY_LSB = IN_VAL_LSB + DATA_W;
    localparam int OUT_TUSER_W  = 2;

    // Divider: the quotient is known to fit 33 bits once the overflow check passed.
    localparam int QUO_W      = 33;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DIV_CNT_W  = 6;
    localparam int BASE_W     = 35;

    localparam logic signed [DATA_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] RES_MIN = 32'sh8000_0000;

    // Datapath operations.
    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_IDLE    = 4'd1;
    localparam op_t OP_PROBE   = 4'd2;
    localparam op_t OP_CMP     = 4'd3;
    localparam op_t OP_RDLO    = 4'd4;
    localparam op_t OP_RDHI    = 4'd5;
    localparam op_t OP_LATCH   = 4'd6;
    localparam op_t OP_DIFF    = 4'd7;
    localparam op_t OP_MUL     = 4'd8;
    localparam op_t OP_DIVINIT = 4'd9;
    localparam op_t OP_DIVSTEP = 4'd10;
    localparam op_t OP_BASE    = 4'd11;
    localparam op_t OP_FINISH  = 4'd12;
    localparam op_t OP_OUT     = 4'd13;

    // Jump conditions.
    localparam int COND_W = 4;
    typedef logic [COND_W-1:0] cond_t;
    localparam cond_t COND_NEXT        = 4'd0;
    localparam cond_t COND_ALWAYS      = 4'd1;
    localparam cond_t COND_NO_START    = 4'd2;
    localparam cond_t COND_SEARCH_DONE = 4'd3;
    localparam cond_t COND_LAST        = 4'd4;
    localparam cond_t COND_DX_ZERO     = 4'd5;
    localparam cond_t COND_DIV_OVF     = 4'd6;
    localparam cond_t COND_DIV_MORE    = 4'd7;
    localparam cond_t COND_OUT_WAIT    = 4'd8;

    // Program steps.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_PROBE   = 4'd1;
    localparam step_t STEP_CMP     = 4'd2;
    localparam step_t STEP_RDLO    = 4'd3;
    localparam step_t STEP_RDHI    = 4'd4;
    localparam step_t STEP_LATCH   = 4'd5;
    localparam step_t STEP_DIFF    = 4'd6;
    localparam step_t STEP_MUL     = 4'd7;
    localparam step_t STEP_DIVINIT = 4'd8;
    localparam step_t STEP_DIVSTEP = 4'd9;
    localparam step_t STEP_BASE    = 4'd10;
    localparam step_t STEP_FINISH  = 4'd11;
    localparam step_t STEP_OUT     = 4'd12;
    localparam step_t STEP_RETURN  = 4'd13;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic search_done;
        logic last;
        logic dx_zero;
        logic div_ovf;
        logic div_more;
    } dp_status_t;

    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        unique case (step)
            STEP_IDLE:    w = '{OP_IDLE,    COND_NO_START,    STEP_IDLE};
            STEP_PROBE:   w = '{OP_PROBE,   COND_SEARCH_DONE, STEP_RDLO};
            STEP_CMP:     w = '{OP_CMP,     COND_ALWAYS,      STEP_PROBE};
            STEP_RDLO:    w = '{OP_RDLO,    COND_NEXT,        STEP_IDLE};
            STEP_RDHI:    w = '{OP_RDHI,    COND_NEXT,        STEP_IDLE};
            STEP_LATCH:   w = '{OP_LATCH,   COND_LAST,        STEP_OUT};
            STEP_DIFF:    w = '{OP_DIFF,    COND_DX_ZERO,     STEP_OUT};
            STEP_MUL:     w = '{OP_MUL,     COND_NEXT,        STEP_IDLE};
            STEP_DIVINIT: w = '{OP_DIVINIT, COND_DIV_OVF,     STEP_OUT};
            STEP_DIVSTEP: w = '{OP_DIVSTEP, COND_DIV_MORE,    STEP_DIVSTEP};
            STEP_BASE:    w = '{OP_BASE,    COND_NEXT,        STEP_IDLE};
            STEP_FINISH:  w = '{OP_FINISH,  COND_NEXT,        STEP_IDLE};
            STEP_OUT:     w = '{OP_OUT,     COND_OUT_WAIT,    STEP_OUT};
            STEP_RETURN:  w = '{OP_NOP,     COND_ALWAYS,      STEP_IDLE};
            default:      w = '{OP_NOP,     COND_ALWAYS,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/tbi_table.sv =====
// ----------------------------------------------------------------------------
// Breakpoint table
// Key and value memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tbi_table (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [tbi_pkg::IDX_W-1:0]          wr_addr,
    input  logic [tbi_pkg::DATA_W-1:0]         wr_key,
    input  logic [tbi_pkg::DATA_W-1:0]         wr_value,
    input  logic [tbi_pkg::IDX_W-1:0]          rd_addr,
    output logic [tbi_pkg::DATA_W-1:0]         rd_key,
    output logic [tbi_pkg::DATA_W-1:0]         rd_value
);

    logic [tbi_pkg::DATA_W-1:0] key_mem [tbi_pkg::TABLE_DEPTH];
    logic [tbi_pkg::DATA_W-1:0] val_mem [tbi_pkg::TABLE_DEPTH];
    logic [tbi_pkg::DATA_W-1:0] rd_key_reg;
    logic [tbi_pkg::DATA_W-1:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_value;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= val_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

// ===== hdl/tbi_sequencer.sv =====
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter, microcode ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module tbi_sequencer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    out_free,
    input  tbi_pkg::dp_status_t     status,
    output tbi_pkg::ctrl_word_t     ctrl
);

    tbi_pkg::step_t pc_reg;
    tbi_pkg::step_t pc_next;
    logic           jump;

    assign ctrl = tbi_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            tbi_pkg::COND_NEXT:        jump = 1'b0;
            tbi_pkg::COND_ALWAYS:      jump = 1'b1;
            tbi_pkg::COND_NO_START:    jump = !start;
            tbi_pkg::COND_SEARCH_DONE: jump = status.search_done;
            tbi_pkg::COND_LAST:        jump = status.last;
            tbi_pkg::COND_DX_ZERO:     jump = status.dx_zero;
            tbi_pkg::COND_DIV_OVF:     jump = status.div_ovf;
            tbi_pkg::COND_DIV_MORE:    jump = status.div_more;
            tbi_pkg::COND_OUT_WAIT:    jump = !out_free;
            default:                   jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + tbi_pkg::step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tbi_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/tbi_datapath.sv =====
// ----------------------------------------------------------------------------
// Interpolation datapath
// Search bounds, segment registers, multiplier, restoring divider and the
// rounding and clipping stage, each driven by the current microcode op.
// ----------------------------------------------------------------------------
module tbi_datapath (
    input  logic                               clk,
    input  tbi_pkg::op_t                       op,
    input  logic                               start,
    input  logic [tbi_pkg::CNT_W-1:0]          entries_in_use,
    input  logic signed [tbi_pkg::DATA_W-1:0]  query_key,
    input  logic [tbi_pkg::DATA_W-1:0]         rd_key,
    input  logic [tbi_pkg::DATA_W-1:0]         rd_value,
    output logic [tbi_pkg::IDX_W-1:0]          rd_addr,
    output tbi_pkg::dp_status_t                status,
    output logic [tbi_pkg::DATA_W-1:0]         result_value,
    output logic                               degenerate_segment,
    output logic                               saturated
);

    localparam int DW = tbi_pkg::DATA_W;
    localparam int IW = tbi_pkg::IDX_W;
    localparam int BW = tbi_pkg::BASE_W;

    logic signed [DW-1:0]          q_reg;
    logic [IW-1:0]                 lo_reg;
    logic [IW-1:0]                 hi_reg;
    logic [IW-1:0]                 last_reg;
    logic [IW-1:0]                 mid_reg;
    logic signed [DW-1:0]          x0_reg;
    logic signed [DW-1:0]          y0_reg;
    logic signed [DW-1:0]          x1_reg;
    logic signed [DW-1:0]          y1_reg;
    logic [DW-1:0]                 mdx_reg;
    logic [DW-1:0]                 mdy_reg;
    logic [DW-1:0]                 mdq_reg;
    logic                          neg_reg;
    logic [tbi_pkg::PROD_W-1:0]    prod_reg;
    logic [DW-1:0]                 rem_reg;
    logic [tbi_pkg::QUO_W-1:0]     qsh_reg;
    logic [tbi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic signed [BW-1:0]          base_reg;
    logic [DW-1:0]                 res_reg;
    logic                          deg_reg;
    logic                          sat_reg;

    logic [IW:0]                   mid_sum;
    logic [IW-1:0]                 mid_c;
    logic [tbi_pkg::CLAMP_W-1:0]   count_ext;
    logic [tbi_pkg::CLAMP_W-1:0]   last_ext;
    logic signed [DW:0]            dx_c;
    logic signed [DW:0]            dy_c;
    logic signed [DW:0]            dq_c;
    logic [DW:0]                   adx_c;
    logic [DW:0]                   ady_c;
    logic [DW:0]                   adq_c;
    logic [DW:0]                   trial_c;
    logic [DW:0]                   diff_c;
    logic                          ge_c;
    logic signed [BW-1:0]          y0_ext;
    logic signed [BW-1:0]          quo_ext;
    logic signed [BW-1:0]          adj_c;
    logic                          pos_ovf;
    logic                          neg_ovf;

    // Search probe: upper middle of the remaining range.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (IW+1)'(1);
    assign mid_c   = mid_sum[IW:1];

    // Entry count clamped to 1..TABLE_DEPTH, kept as the index of the last entry.
    always_comb
    begin
        count_ext = tbi_pkg::CLAMP_W'(entries_in_use);
        if (count_ext == '0)
        begin
            last_ext = '0;
        end
        else if (count_ext > tbi_pkg::CLAMP_W'(tbi_pkg::TABLE_DEPTH))
        begin
            last_ext = tbi_pkg::CLAMP_W'(tbi_pkg::TABLE_DEPTH - 1);
        end
        else
        begin
            last_ext = count_ext - tbi_pkg::CLAMP_W'(1);
        end
    end

    always_comb
    begin
        unique case (op)
            tbi_pkg::OP_PROBE: rd_addr = mid_c;
            tbi_pkg::OP_RDHI:  rd_addr = lo_reg + IW'(1);
            default:           rd_addr = lo_reg;
        endcase
    end

    // Segment differences and magnitudes.
    assign dx_c  = {x1_reg[DW-1], x1_reg} - {x0_reg[DW-1], x0_reg};
    assign dy_c  = {y1_reg[DW-1], y1_reg} - {y0_reg[DW-1], y0_reg};
    assign dq_c  = {q_reg[DW-1], q_reg} - {x0_reg[DW-1], x0_reg};
    assign adx_c = dx_c[DW] ? -dx_c : dx_c;
    assign ady_c = dy_c[DW] ? -dy_c : dy_c;
    assign adq_c = dq_c[DW] ? -dq_c : dq_c;

    // One restoring divide step.
    assign trial_c = {rem_reg, qsh_reg[tbi_pkg::QUO_W-1]};
    assign ge_c    = trial_c >= {1'b0, mdx_reg};
    assign diff_c  = trial_c - {1'b0, mdx_reg};

    assign y0_ext  = BW'(y0_reg);
    assign quo_ext = $signed({{(BW - tbi_pkg::QUO_W){1'b0}}, qsh_reg});

    // A nonzero remainder moves the result one step toward zero where needed.
    always_comb
    begin
        adj_c = base_reg;
        if (rem_reg != '0)
        begin
            if (neg_reg && base_reg > 0)
            begin
                adj_c = base_reg - BW'(1);
            end
            else if (!neg_reg && base_reg < 0)
            begin
                adj_c = base_reg + BW'(1);
            end
        end
        pos_ovf = !adj_c[BW-1] && (adj_c[BW-2:DW-1] != '0);
        neg_ovf =  adj_c[BW-1] && (adj_c[BW-2:DW-1] != '1);
    end

    always_ff @(posedge clk)
    begin
        case (op)
            tbi_pkg::OP_IDLE:
            begin
                if (start)
                begin
                    q_reg    <= query_key;
                    lo_reg   <= '0;
                    hi_reg   <= last_ext[IW-1:0];
                    last_reg <= last_ext[IW-1:0];
                end
            end
            tbi_pkg::OP_PROBE:
            begin
                mid_reg <= mid_c;
            end
            tbi_pkg::OP_CMP:
            begin
                if ($signed(rd_key) <= q_reg)
                begin
                    lo_reg <= mid_reg;
                end
                else
                begin
                    hi_reg <= mid_reg - IW'(1);
                end
            end
            tbi_pkg::OP_RDHI:
            begin
                x0_reg <= rd_key;
                y0_reg <= rd_value;
            end
            tbi_pkg::OP_LATCH:
            begin
                x1_reg  <= rd_key;
                y1_reg  <= rd_value;
                res_reg <= y0_reg;
                deg_reg <= 1'b0;
                sat_reg <= 1'b0;
            end
            tbi_pkg::OP_DIFF:
            begin
                mdx_reg <= adx_c[DW-1:0];
                mdy_reg <= ady_c[DW-1:0];
                mdq_reg <= adq_c[DW-1:0];
                neg_reg <= dx_c[DW] ^ dy_c[DW] ^ dq_c[DW];
                deg_reg <= (dx_c == '0);
            end
            tbi_pkg::OP_MUL:
            begin
                prod_reg <= mdy_reg * mdq_reg;
            end
            tbi_pkg::OP_DIVINIT:
            begin
                rem_reg <= {1'b0, prod_reg[tbi_pkg::PROD_W-1:tbi_pkg::QUO_W]};
                qsh_reg <= prod_reg[tbi_pkg::QUO_W-1:0];
                cnt_reg <= tbi_pkg::DIV_CNT_W'(tbi_pkg::QUO_W);
                res_reg <= neg_reg ? tbi_pkg::RES_MIN : tbi_pkg::RES_MAX;
                sat_reg <= 1'b1;
            end
            tbi_pkg::OP_DIVSTEP:
            begin
                rem_reg <= ge_c ? diff_c[DW-1:0] : trial_c[DW-1:0];
                qsh_reg <= {qsh_reg[tbi_pkg::QUO_W-2:0], ge_c};
                cnt_reg <= cnt_reg - tbi_pkg::DIV_CNT_W'(1);
            end
            tbi_pkg::OP_BASE:
            begin
                base_reg <= neg_reg ? (y0_ext - quo_ext) : (y0_ext + quo_ext);
            end
            tbi_pkg::OP_FINISH:
            begin
                if (pos_ovf)
                begin
                    res_reg <= tbi_pkg::RES_MAX;
                end
                else if (neg_ovf)
                begin
                    res_reg <= tbi_pkg::RES_MIN;
                end
                else
                begin
                    res_reg <= adj_c[DW-1:0];
                end
                sat_reg <= pos_ovf || neg_ovf;
            end
            default:
            begin
            end
        endcase
    end

    assign status.search_done = !(lo_reg < hi_reg);
    assign status.last        = (lo_reg == last_reg);
    assign status.dx_zero     = (dx_c == '0);
    assign status.div_ovf     = {1'b0, prod_reg[tbi_pkg::PROD_W-1:tbi_pkg::QUO_W]} >= mdx_reg;
    assign status.div_more    = (cnt_reg != tbi_pkg::DIV_CNT_W'(1));

    assign result_value       = res_reg;
    assign degenerate_segment = deg_reg;
    assign saturated          = sat_reg;

endmodule

// ===== hdl/table_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Table interpolator
// Piecewise-linear lookup table with binary search, run by a microcode
// sequencer over a shared datapath.
// ----------------------------------------------------------------------------
// The slave stream takes requests. tuser selects the kind: 0 writes one
// breakpoint (entry_index, entry_key, entry_value), 1 looks up query_key.
// A load gives no result. A lookup gives one result on the master stream:
// result_value in tdata, the two flags in tuser. A lookup runs the
// binary-search probes (at most 6) and a final check, then the reads,
// differences, the 32 x 32 product and the overflow test, a restoring
// divide for 33 quotient bits, and the steps that round, clip and load the
// output register. A lookup that ends on the last entry, on equal keys or
// on a sure overflow skips the divide. Requests are taken only in the idle
// step, which follows the output and return steps, so one lookup runs at a
// time. Results go into an output register; the next request is taken while a
// result still waits there, and a lookup that finishes while the register
// is full waits in its output step until the receiver takes the result.
// The user must write the entry count through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this.
// Reset sets the entry count to 1 and empties the output register; the
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module table_interpolator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[5:0], entry_key[37:6], entry_value[69:38], query_key[101:70]
    input  logic [tbi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_value[31:0]
    output logic [tbi_pkg::DATA_W-1:0]          m_axis_tdata,
    // degenerate_segment[0], saturated[1]
    output logic [tbi_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [tbi_pkg::CNT_W-1:0]           cfg_wdata
);

    tbi_pkg::ctrl_word_t        ctrl;
    tbi_pkg::dp_status_t        status;
    logic                       accept;
    logic                       start;
    logic                       wr_en;
    logic                       out_free;
    logic                       out_load;
    logic [tbi_pkg::IDX_W-1:0]  rd_addr;
    logic [tbi_pkg::DATA_W-1:0] rd_key;
    logic [tbi_pkg::DATA_W-1:0] rd_value;
    logic [tbi_pkg::DATA_W-1:0] res_value;
    logic                       res_deg;
    logic                       res_sat;
    logic [tbi_pkg::CNT_W-1:0]  count_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [tbi_pkg::DATA_W-1:0] out_data_reg;
    logic [tbi_pkg::OUT_TUSER_W-1:0] out_user_reg;

    assign s_axis_tready = (ctrl.op == tbi_pkg::OP_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && s_axis_tuser;
    assign wr_en         = accept && !s_axis_tuser;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (ctrl.op == tbi_pkg::OP_OUT) && out_free;

    tbi_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl)
    );

    tbi_table u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (tbi_pkg::IDX_W'(s_axis_tdata[tbi_pkg::IN_IDX_W-1:0])),
        .wr_key   (s_axis_tdata[tbi_pkg::IN_KEY_LSB +: tbi_pkg::DATA_W]),
        .wr_value (s_axis_tdata[tbi_pkg::IN_VAL_LSB +: tbi_pkg::DATA_W]),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    tbi_datapath u_dp (
        .clk                (clk),
        .op                 (ctrl.op),
        .start              (start),
        .entries_in_use     (count_reg),
        .query_key          ($signed(s_axis_tdata[tbi_pkg::IN_QUERY_LSB +: tbi_pkg::DATA_W])),
        .rd_key             (rd_key),
        .rd_value           (rd_value),
        .rd_addr            (rd_addr),
        .status             (status),
        .result_value       (res_value),
        .degenerate_segment (res_deg),
        .saturated          (res_sat)
    );

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= tbi_pkg::CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_value;
            out_user_reg <= {res_sat, res_deg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== sim/table_interpolator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table interpolator regression
// Loads breakpoint tables of several shapes, looks up keys inside segments,
// on breakpoints, below the first key and beyond the last, and compares
// every result with a behavioral prediction kept in a scoreboard. Both
// streams idle at random, and the entry count is changed between phases.
// ----------------------------------------------------------------------------
module table_interpolator_top_test;

    localparam int     ITEM_TARGET     = 1350;
    localparam int     STALL_LIMIT     = 4000;
    localparam int     HOLD_OFF_CYCLES = 800;
    localparam int     SETTLE_CYCLES   = 80;
    localparam int     DRAIN_CYCLES    = 100;
    localparam int     FLAG_DEGENERATE = 0;
    localparam int     FLAG_SATURATED  = 1;
    localparam longint KEY_MIN         = -64'sd2147483648;
    localparam longint KEY_MAX         = 64'sd2147483647;

    typedef enum bit {REQ_LOAD = 1'b0, REQ_LOOKUP = 1'b1} req_kind_t;

    typedef struct packed {
        logic signed [tbi_pkg::DATA_W-1:0] value;
        logic                              degenerate;
        logic                              saturated;
    } lookup_result_t;

    class lookup_scoreboard;
        logic signed [tbi_pkg::DATA_W-1:0] bp_key [tbi_pkg::TABLE_DEPTH];
        logic signed [tbi_pkg::DATA_W-1:0] bp_value [tbi_pkg::TABLE_DEPTH];
        logic [tbi_pkg::CNT_W-1:0]         entry_count;
        lookup_result_t                    results_due[$];
        int                                errors;

        function new();
            entry_count = 1;
            errors = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function lookup_result_t interpolate(input logic signed [tbi_pkg::DATA_W-1:0] query);
            int             n, lo, hi, mid;
            longint         q, x0, y0, x1, y1, dx, dy, dq, base, res;
            logic [63:0]    ady, adq, prod, dmag, tmag, rem;
            bit             neg;
            lookup_result_t r;
            n = int'(entry_count);
            if (n < 1)
                n = 1;
            if (n > tbi_pkg::TABLE_DEPTH)
                n = tbi_pkg::TABLE_DEPTH;
            q = longint'(query);
            lo = 0;
            hi = n - 1;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                if (longint'(bp_key[mid]) <= q)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            r = '0;
            y0 = longint'(bp_value[lo]);
            r.value = bp_value[lo];
            if (lo == n - 1)
                return r;
            x0 = longint'(bp_key[lo]);
            x1 = longint'(bp_key[lo + 1]);
            y1 = longint'(bp_value[lo + 1]);
            dx = x1 - x0;
            if (dx == 0)
            begin
                r.degenerate = 1'b1;
                return r;
            end
            dy = y1 - y0;
            dq = q - x0;
            ady = (dy < 0) ? -dy : dy;
            adq = (dq < 0) ? -dq : dq;
            dmag = (dx < 0) ? -dx : dx;
            prod = ady * adq;
            tmag = prod / dmag;
            rem = prod % dmag;
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            if (tmag >= 64'h2_0000_0000)
                res = neg ? KEY_MIN - 64'sd1 : KEY_MAX + 64'sd1;
            else
            begin
                base = neg ? y0 - longint'(tmag) : y0 + longint'(tmag);
                // The result is truncated toward zero of the exact value, not of the offset.
                if (rem != 0)
                begin
                    if (neg && base > 0)
                        base = base - 1;
                    else if (!neg && base < 0)
                        base = base + 1;
                end
                res = base;
            end
            if (res > KEY_MAX)
            begin
                res = KEY_MAX;
                r.saturated = 1'b1;
            end
            else if (res < KEY_MIN)
            begin
                res = KEY_MIN;
                r.saturated = 1'b1;
            end
            r.value = res[31:0];
            return r;
        endfunction

        function void note_request(input req_kind_t kind,
                                   input logic [tbi_pkg::IN_TDATA_W-1:0] payload);
            logic [tbi_pkg::IN_IDX_W-1:0] slot;
            slot = payload[tbi_pkg::IN_IDX_W-1:0];
            if (kind == REQ_LOAD)
            begin
                bp_key[slot] = payload[tbi_pkg::IN_KEY_LSB +: tbi_pkg::DATA_W];
                bp_value[slot] = payload[tbi_pkg::IN_VAL_LSB +: tbi_pkg::DATA_W];
            end
            else
                results_due.push_back(
                    interpolate(payload[tbi_pkg::IN_QUERY_LSB +: tbi_pkg::DATA_W]));
        endfunction

        function void check_result(input logic [tbi_pkg::DATA_W-1:0] value,
                                   input logic [tbi_pkg::OUT_TUSER_W-1:0] flags);
            lookup_result_t want;
            if (results_due.size() == 0)
            begin
                $error("result_value: expected no result, actual %0d", $signed(value));
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (value !== want.value)
            begin
                $error("result_value: expected %0d, actual %0d", want.value, $signed(value));
                errors++;
            end
            if (flags[FLAG_DEGENERATE] !== want.degenerate)
            begin
                $error("degenerate_segment: expected %0d, actual %0d",
                       want.degenerate, flags[FLAG_DEGENERATE]);
                errors++;
            end
            if (flags[FLAG_SATURATED] !== want.saturated)
            begin
                $error("saturated: expected %0d, actual %0d",
                       want.saturated, flags[FLAG_SATURATED]);
                errors++;
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [tbi_pkg::IN_TDATA_W-1:0]      s_axis_tdata;
    logic                                s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [tbi_pkg::DATA_W-1:0]          m_axis_tdata;
    logic [tbi_pkg::OUT_TUSER_W-1:0]     m_axis_tuser;
    logic                                cfg_we;
    logic [tbi_pkg::CNT_W-1:0]           cfg_wdata;

    lookup_scoreboard lookups = new();
    longint           tbl_key [tbi_pkg::TABLE_DEPTH];
    int               items_sent;
    bit               sender_steady;
    int               hold_off_requests;

    table_interpolator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                lookups.entry_count = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                lookups.note_request(req_kind_t'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                lookups.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_request(input req_kind_t kind, input logic [5:0] idx,
                                input logic [31:0] key, input logic [31:0] value,
                                input logic [31:0] query);
        int r;
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, query, value, key, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        r = $urandom_range(0, 99);
        if (sender_steady || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(30, 120);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic load_entry(input int idx, input logic [31:0] key, input logic [31:0] value);
        tbl_key[idx] = longint'($signed(key));
        send_request(REQ_LOAD, idx[5:0], key, value, $urandom);
    endtask

    task automatic look_up(input logic [31:0] query);
        send_request(REQ_LOOKUP, 6'($urandom_range(0, 63)), $urandom, $urandom, query);
    endtask

    // Waits until no lookup is outstanding and the block has settled, then
    // writes the entry count.
    task automatic set_entry_count(input logic [tbi_pkg::CNT_W-1:0] count);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (lookups.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random ready pattern, with one long hold-off on request.
    initial
    begin : result_sink
        int r;
        int len;
        bit rdy;
        int served;
        served = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_requests != served)
            begin
                served = hold_off_requests;
                rdy = 1'b0;
                len = HOLD_OFF_CYCLES;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    rdy = 1'b1;
                    len = $urandom_range(1, 24);
                end
                else if (r < 62)
                begin
                    rdy = 1'b1;
                    len = $urandom_range(100, 300);
                end
                else if (r < 92)
                begin
                    rdy = 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    rdy = 1'b0;
                    len = $urandom_range(15, 120);
                end
            end
            m_axis_tready <= rdy;
            repeat (len - 1) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int     phase, n, style, lookup_count, r, i, k, cfg, small_val;
        longint span, step_max, lo_key, hi_key, q;

        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        items_sent        = 0;
        sender_steady     = 1'b0;
        hold_off_requests = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A single breakpoint after reset: every key returns its value.
        load_entry(0, 32'h0001_0000, 32'h0064_0000);
        look_up(32'h8000_0000);
        look_up(32'h7FFF_FFFF);
        // An entry count of zero behaves as one.
        set_entry_count(7'd0);
        look_up(32'h0000_1234);

        set_entry_count(7'd4);
        load_entry(1, 32'h0003_0000, 32'hFF9C_0000);
        load_entry(2, 32'h0003_0000, 32'h7FFF_FFFF);
        load_entry(3, 32'h7FFF_FFFF, 32'h8000_0000);
        look_up(32'h0002_0000);
        look_up(32'h0002_0001);
        look_up(32'h0003_0000);
        look_up(32'h7FFF_FFFF);
        // Far below the first key the first segment runs past the top bound.
        look_up(32'h8000_0000);
        // First two keys equal and the query below them.
        load_entry(1, 32'h0001_0000, 32'hFF9C_0000);
        look_up(32'h0000_0000);
        // Steep first segment: extrapolation runs past the bottom bound.
        load_entry(1, 32'h0001_0001, 32'h7FFF_FFFF);
        load_entry(0, 32'h0001_0000, 32'h8000_0000);
        look_up(32'h8000_0000);
        // An unsorted table still searches and interpolates.
        load_entry(2, 32'h8000_0000, 32'h0000_0000);
        look_up(32'h0002_0000);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 8)
                0:       cfg = 64;
                1:       cfg = 127;
                2:       cfg = 2;
                3:       cfg = 0;
                4:       cfg = 1;
                default: cfg = $urandom_range(3, 127);
            endcase
            set_entry_count(cfg[6:0]);
            n = (cfg < 1) ? 1 : (cfg > tbi_pkg::TABLE_DEPTH) ? tbi_pkg::TABLE_DEPTH : cfg;
            style = $urandom_range(0, 9);
            sender_steady = ($urandom_range(0, 4) == 0);

            // Style 7 is an unsorted table, 6 sorted with repeated keys, 8 spans
            // the whole key range, 9 holds full-range values.
            if (style == 7)
            begin
                for (i = 0; i < n; i++)
                    load_entry(i, $urandom, $urandom);
            end
            else
            begin
                span = (style == 8) ? 64'hFFFF_FFFF :
                       longint'($urandom_range(16 * n, 32'h0100_0000));
                step_max = span / n;
                lo_key = KEY_MIN + (longint'($urandom) % (64'sh1_0000_0000 - span));
                for (i = 0; i < n; i++)
                begin
                    if (i > 0 && !(style == 6 && $urandom_range(0, 3) == 0))
                        lo_key = lo_key + longint'($urandom_range(1, 32'(step_max)));
                    if (style == 9 || $urandom_range(0, 1) == 1)
                        load_entry(i, lo_key[31:0], $urandom);
                    else
                    begin
                        small_val = $urandom_range(0, 32'h0200_0000);
                        small_val = small_val - 32'h0100_0000;
                        load_entry(i, lo_key[31:0], small_val);
                    end
                end
            end

            // The receiver stalls for a long stretch while lookups keep coming.
            if (phase == 2 || phase == 9)
                hold_off_requests++;

            lookup_count = $urandom_range(30, 80);
            for (k = 0; k < lookup_count; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    load_entry($urandom_range(0, 63), $urandom, $urandom);
                else
                begin
                    if (r < 60)
                    begin
                        if (n == 1)
                            q = longint'($urandom);
                        else
                        begin
                            i = $urandom_range(0, n - 2);
                            lo_key = tbl_key[i];
                            hi_key = tbl_key[i + 1];
                            q = (hi_key > lo_key) ?
                                lo_key + longint'($urandom) % (hi_key - lo_key + 1) : lo_key;
                        end
                    end
                    else if (r < 70)
                        q = tbl_key[$urandom_range(0, n - 1)];
                    else if (r < 80)
                        q = KEY_MIN + longint'($urandom) % (tbl_key[0] - KEY_MIN + 1);
                    else if (r < 90)
                        q = tbl_key[n - 1] + longint'($urandom) % (KEY_MAX - tbl_key[n - 1] + 1);
                    else
                        q = longint'($urandom);
                    look_up(q[31:0]);
                end
            end
            phase++;
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (lookups.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (lookups.errors == 0 && lookups.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
